[rtl/core/swg_pkg.sv]
// ----------------------------------------------------------------------------
// swg_pkg
// Shared types and constants of the swipe-to-wake gesture detector.
// ----------------------------------------------------------------------------
package swg_pkg;

   localparam int COORD_W = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = COORD_W;
   localparam int STAGE_W = 2;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [STAGE_W-1:0] stage_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_ENABLE = 3'd0;
   localparam csr_idx_type CSR_SCREEN_OFF = 3'd1;
   localparam csr_idx_type CSR_FIRST_MARK = 3'd2;
   localparam csr_idx_type CSR_SECOND_MARK = 3'd3;
   localparam csr_idx_type CSR_SCREEN_WIDTH = 3'd4;
   localparam csr_idx_type CSR_FINAL_MARGIN = 3'd5;
   localparam csr_idx_type CSR_LOWER_BAND_Y = 3'd6;

   localparam coord_type RST_FIRST_MARK = 12'd100;
   localparam coord_type RST_SECOND_MARK = 12'd300;
   localparam coord_type RST_SCREEN_WIDTH = 12'd400;
   localparam coord_type RST_FINAL_MARGIN = 12'd50;
   localparam coord_type RST_LOWER_BAND_Y = 12'd800;

   localparam stage_type STAGE_DONE = 2'd2;

   typedef struct packed {
      logic      enable;
      logic      screen_off;
      coord_type first_mark;
      coord_type second_mark;
      coord_type screen_width;
      coord_type final_margin;
      coord_type lower_band_y;
   } cfg_type;

   typedef struct packed {
      coord_type touch_x;
      coord_type touch_y;
      logic      one_finger;
   } sample_type;

   typedef struct packed {
      logic      press_power;
      stage_type sweep_stage;
   } result_type;

endpackage

[rtl/core/swg_req_if.sv]
// ----------------------------------------------------------------------------
// swg_req_if
// Touch sample channel: valid/ready handshake with the sample fields.
// ----------------------------------------------------------------------------
interface swg_req_if;
   logic              valid;
   logic              ready;
   swg_pkg::coord_type touch_x;
   swg_pkg::coord_type touch_y;
   logic              one_finger;

   modport source (output valid, output touch_x, output touch_y, output one_finger,
                   input ready);
   modport sink (input valid, input touch_x, input touch_y, input one_finger,
                 output ready);
endinterface

[rtl/core/swg_rsp_if.sv]
// ----------------------------------------------------------------------------
// swg_rsp_if
// Gesture result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface swg_rsp_if;
   logic              valid;
   logic              ready;
   logic              press_power;
   swg_pkg::stage_type sweep_stage;

   modport source (output valid, output press_power, output sweep_stage, input ready);
   modport sink (input valid, input press_power, input sweep_stage, output ready);
endinterface

[rtl/core/swg_csr.sv]
// ----------------------------------------------------------------------------
// swg_csr
// Configuration registers; a screen_off write requests a progress clear.
// ----------------------------------------------------------------------------
module swg_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  swg_pkg::csr_idx_type         csr_index,
   input  logic [swg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output swg_pkg::cfg_type             cfg,
   output logic                         clear_progress
);

   swg_pkg::cfg_type cfg_ff;
   swg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      clear_progress = 1'b0;
      if (csr_we) begin
         case (csr_index)
            swg_pkg::CSR_ENABLE: cfg_in.enable = csr_wdata[0];
            swg_pkg::CSR_SCREEN_OFF: begin
               cfg_in.screen_off = csr_wdata[0];
               clear_progress = 1'b1;
            end
            swg_pkg::CSR_FIRST_MARK: cfg_in.first_mark = csr_wdata;
            swg_pkg::CSR_SECOND_MARK: cfg_in.second_mark = csr_wdata;
            swg_pkg::CSR_SCREEN_WIDTH: cfg_in.screen_width = csr_wdata;
            swg_pkg::CSR_FINAL_MARGIN: cfg_in.final_margin = csr_wdata;
            swg_pkg::CSR_LOWER_BAND_Y: cfg_in.lower_band_y = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b0;
         cfg_ff.screen_off <= 1'b0;
         cfg_ff.first_mark <= swg_pkg::RST_FIRST_MARK;
         cfg_ff.second_mark <= swg_pkg::RST_SECOND_MARK;
         cfg_ff.screen_width <= swg_pkg::RST_SCREEN_WIDTH;
         cfg_ff.final_margin <= swg_pkg::RST_FINAL_MARGIN;
         cfg_ff.lower_band_y <= swg_pkg::RST_LOWER_BAND_Y;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/swg_tracker.sv]
// ----------------------------------------------------------------------------
// swg_tracker
// Swipe progress latches and the per-sample range tests.
// ----------------------------------------------------------------------------
module swg_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  swg_pkg::cfg_type     cfg,
   input  logic                 clear_progress,
   input  logic                 advance,
   input  swg_pkg::sample_type  sample,
   output swg_pkg::result_type  result
);

   logic first_ff, second_ff, armed_ff;
   logic first_in, second_in, armed_in;
   logic first_nx, second_nx, armed_nx;

   // 13-bit signed compares; edge goes negative when margin exceeds width
   logic signed [swg_pkg::COORD_W:0] x_s, y_s, m1_s, m2_s, edge_s, margin_s, band_s;
   logic in_band, s1, s2, fin, press;

   always_comb begin
      x_s = $signed({1'b0, sample.touch_x});
      y_s = $signed({1'b0, sample.touch_y});
      m1_s = $signed({1'b0, cfg.first_mark});
      m2_s = $signed({1'b0, cfg.second_mark});
      margin_s = $signed({1'b0, cfg.final_margin});
      band_s = $signed({1'b0, cfg.lower_band_y});
      edge_s = $signed({1'b0, cfg.screen_width}) - margin_s;

      if (cfg.screen_off) begin
         in_band = (y_s > 0);
         s1 = (x_s > 0) && (x_s < m1_s) && in_band;
         s2 = (x_s > m1_s) && (x_s < m2_s) && in_band;
         fin = (x_s > m2_s) && in_band && (x_s > edge_s);
      end else begin
         in_band = (y_s > band_s);
         s1 = (x_s < edge_s) && (x_s > m2_s) && in_band;
         s2 = (x_s < m2_s) && (x_s > m1_s) && in_band;
         fin = (x_s < m1_s) && in_band && (x_s < margin_s);
      end

      first_nx = first_ff;
      second_nx = second_ff;
      armed_nx = armed_ff;
      press = 1'b0;
      if (!sample.one_finger) begin
         first_nx = 1'b0;
         second_nx = 1'b0;
         armed_nx = 1'b1;
      end else if (cfg.enable) begin
         if (first_ff || s1) begin
            first_nx = 1'b1;
            if (second_ff || s2) begin
               second_nx = 1'b1;
               if (fin && armed_ff) begin
                  press = 1'b1;
                  armed_nx = 1'b0;
               end
            end
         end
      end

      result.press_power = press;
      result.sweep_stage = swg_pkg::stage_type'({1'b0, first_nx}) +
                           swg_pkg::stage_type'({1'b0, second_nx});

      first_in = first_ff;
      second_in = second_ff;
      armed_in = armed_ff;
      if (clear_progress) begin
         first_in = 1'b0;
         second_in = 1'b0;
         armed_in = 1'b1;
      end else if (advance) begin
         first_in = first_nx;
         second_in = second_nx;
         armed_in = armed_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
         second_ff <= 1'b0;
         armed_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
         second_ff <= second_in;
         armed_ff <= armed_in;
      end
   end

`ifndef SYNTH
   a_press_needs_armed: assert property (@(posedge clock) disable iff (reset)
      result.press_power |-> armed_ff)
      else $error("press raised while disarmed");

   a_press_disarms: assert property (@(posedge clock) disable iff (reset)
      advance && result.press_power && !clear_progress |=> !armed_ff)
      else $error("still armed after a press transfer");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> first_ff)
      else $error("second mark latched without first");
`endif

endmodule

[rtl/core/swipe_wake_gesture_detector.sv]
// ----------------------------------------------------------------------------
// swipe_wake_gesture_detector
// Follows a horizontal swipe over touch samples and requests a power press.
//
//  port       dir  kind            fields
//  req_chan   in   valid/ready     touch_x[12] touch_y[12] one_finger
//  rsp_chan   out  valid/ready     press_power sweep_stage[2]
//  csr_*      in   write strobe    csr_index[3] csr_wdata[12]
//
// One sample per cycle while the result register is not stalled; each result is registered.
// Path: input register -> range compares and latch update -> result register.
// Reset (synchronous) empties both registers and restores the register defaults.
// A stalled result register holds the input register, which then drops ready.
// ----------------------------------------------------------------------------
module swipe_wake_gesture_detector (
   input  logic                         clock,
   input  logic                         reset,
   swg_req_if.sink                      req_chan,
   swg_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  swg_pkg::csr_idx_type         csr_index,
   input  logic [swg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   swg_pkg::cfg_type    cfg;
   logic                clear_progress;
   swg_pkg::sample_type in_data_ff, in_data_in;
   logic                in_valid_ff, in_valid_in;
   swg_pkg::result_type out_data_ff, out_data_in, result;
   logic                out_valid_ff, out_valid_in;
   logic                out_free, advance;

   swg_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cfg            (cfg),
      .clear_progress (clear_progress)
   );

   swg_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .clear_progress (clear_progress),
      .advance        (advance),
      .sample         (in_data_ff),
      .result         (result)
   );

   always_comb begin
      out_free = !out_valid_ff || rsp_chan.ready;
      advance = in_valid_ff && out_free;
      req_chan.ready = !in_valid_ff || out_free;

      in_valid_in = (in_valid_ff && !advance) || (req_chan.valid && req_chan.ready);
      in_data_in = in_data_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_data_in.touch_x = req_chan.touch_x;
         in_data_in.touch_y = req_chan.touch_y;
         in_data_in.one_finger = req_chan.one_finger;
      end

      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      out_data_in = advance ? result : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.press_power = out_data_ff.press_power;
   assign rsp_chan.sweep_stage = out_data_ff.sweep_stage;

`ifndef SYNTH
   a_press_at_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.press_power |-> rsp_chan.sweep_stage == swg_pkg::STAGE_DONE)
      else $error("press reported before both marks");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_data_ff))
      else $error("pending sample lost while result stalled");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.sweep_stage != 2'd3)
      else $error("sweep stage out of range");
`endif

endmodule
